FILE: rtl/top_k_longest_transfers_macros.svh
// Assertion macros shared by the top-k longest transfers RTL.
`ifndef TOP_K_LONGEST_TRANSFERS_MACROS_SVH
`define TOP_K_LONGEST_TRANSFERS_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TKLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TKLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tklt_pkg.sv
// Types and constants for the top-k longest transfers block.
package tklt_pkg;

  localparam int TOP_COUNT = 16;
  localparam int IDX_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int CNT_W     = $clog2(TOP_COUNT + 1);

  localparam int WIDE_W  = 64;
  localparam int ID_W    = 16;
  localparam int RIDX_W  = 4;
  localparam int RANK_W  = 4;
  localparam int ECNT_W  = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } tklt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

FILE: rtl/tklt_ctrl.sv
// Sequencer for the top-k list: capture, compare, then update and result load.
`include "top_k_longest_transfers_macros.svh"

module tklt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tklt_pkg::ctl_sts_t  sts,
  output tklt_pkg::ctl_cmd_t  cmd
);
  import tklt_pkg::*;

  tklt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.compare = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        // hold here until the output register can take the result
        if (sts.out_free) begin
          cmd.commit  = 1'b1;
          in_ready    = 1'b1;
          cmd.capture = in_valid;
          state_nxt   = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TKLT_ASSERT_NEXT(a_cmp_then_upd, state_r == ST_CMP, state_r == ST_UPD, "compare not followed by update")
  `TKLT_ASSERT(a_overlap_commit, (in_valid && in_ready && state_r == ST_UPD) |-> cmd.commit, "word taken in update without commit")
  `TKLT_ASSERT(a_ready_idle, (state_r == ST_IDLE) |-> in_ready, "not ready while idle")

endmodule

FILE: rtl/tklt_datapath.sv
// Entry registers, parallel duration compare, shift insert and result register.
`include "top_k_longest_transfers_macros.svh"

module tklt_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tklt_pkg::ctl_cmd_t               cmd,
  output tklt_pkg::ctl_sts_t               sts,
  input  logic                             in_req_type,
  input  logic [tklt_pkg::WIDE_W-1:0]      in_duration,
  input  logic [tklt_pkg::WIDE_W-1:0]      in_xfer_size,
  input  logic [tklt_pkg::WIDE_W-1:0]      in_xfer_address,
  input  logic [tklt_pkg::ID_W-1:0]        in_context_id,
  input  logic [tklt_pkg::ID_W-1:0]        in_queue_id,
  input  logic [tklt_pkg::WIDE_W-1:0]      in_start_time,
  input  logic [tklt_pkg::RIDX_W-1:0]      in_read_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kept,
  output logic [tklt_pkg::RANK_W-1:0]      out_rank,
  output logic [tklt_pkg::ECNT_W-1:0]      out_entry_count,
  output logic                             out_rd_valid,
  output logic [tklt_pkg::WIDE_W-1:0]      out_rd_duration,
  output logic [tklt_pkg::WIDE_W-1:0]      out_rd_size,
  output logic [tklt_pkg::WIDE_W-1:0]      out_rd_address,
  output logic [tklt_pkg::ID_W-1:0]        out_rd_context_id,
  output logic [tklt_pkg::ID_W-1:0]        out_rd_queue_id,
  output logic [tklt_pkg::WIDE_W-1:0]      out_rd_start_time
);
  import tklt_pkg::*;

  // captured request word
  logic              req_type_r;
  logic [WIDE_W-1:0] req_dur_r, req_size_r, req_addr_r, req_start_r;
  logic [ID_W-1:0]   req_ctx_r, req_queue_r;
  logic [RIDX_W-1:0] req_idx_r;

  // sorted entries, longest first
  logic [WIDE_W-1:0] e_dur_r   [TOP_COUNT];
  logic [WIDE_W-1:0] e_size_r  [TOP_COUNT];
  logic [WIDE_W-1:0] e_addr_r  [TOP_COUNT];
  logic [WIDE_W-1:0] e_start_r [TOP_COUNT];
  logic [ID_W-1:0]   e_ctx_r   [TOP_COUNT];
  logic [ID_W-1:0]   e_queue_r [TOP_COUNT];
  logic [CNT_W-1:0]  cnt_r;

  // ge: slot at or after the insert point (suffix of ones up to the append slot)
  logic [TOP_COUNT-1:0] ge_nxt, ge_r;
  logic [TOP_COUNT-1:0] at;
  logic [IDX_W-1:0]     ins_rank;
  logic                 ins_kept;
  logic                 is_ins;
  logic                 rd_hit;
  logic [IDX_W-1:0]     rd_idx;

  logic              out_valid_r;
  logic              kept_r, rd_valid_r;
  logic [RANK_W-1:0] rank_r;
  logic [ECNT_W-1:0] ecnt_r;
  logic [WIDE_W-1:0] rd_dur_r, rd_size_r, rd_addr_r, rd_start_r;
  logic [ID_W-1:0]   rd_ctx_r, rd_queue_r;
  logic [CNT_W-1:0]  cnt_nxt;

  assign sts.out_free = !out_valid_r || out_ready;
  assign is_ins       = (req_type_r == REQ_INSERT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r  <= in_req_type;
      req_dur_r   <= in_duration;
      req_size_r  <= in_xfer_size;
      req_addr_r  <= in_xfer_address;
      req_ctx_r   <= in_context_id;
      req_queue_r <= in_queue_id;
      req_start_r <= in_start_time;
      req_idx_r   <= in_read_index;
    end
  end

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        ge_nxt[i] = req_dur_r > e_dur_r[i];
      end else begin
        ge_nxt[i] = (CNT_W'(i) == cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      ge_r <= ge_nxt;
    end
  end

  always_comb begin
    ins_rank = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      at[i] = ge_r[i] && ((i == 0) || !ge_r[(i > 0) ? i - 1 : 0]);
      if (at[i]) begin
        ins_rank = ins_rank | IDX_W'(i);
      end
    end
  end

  assign ins_kept = |ge_r;
  assign cnt_nxt  = (ins_kept && cnt_r < CNT_W'(TOP_COUNT)) ? cnt_r + CNT_W'(1) : cnt_r;

  // each slot takes the new record at the insert point, or its upper neighbor below it
  for (genvar g = 0; g < TOP_COUNT; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.commit && is_ins) begin
        if (at[g]) begin
          e_dur_r[g]   <= req_dur_r;
          e_size_r[g]  <= req_size_r;
          e_addr_r[g]  <= req_addr_r;
          e_start_r[g] <= req_start_r;
          e_ctx_r[g]   <= req_ctx_r;
          e_queue_r[g] <= req_queue_r;
        end else if ((g > 0) && ge_r[(g > 0) ? g - 1 : 0]) begin
          e_dur_r[g]   <= e_dur_r[(g > 0) ? g - 1 : 0];
          e_size_r[g]  <= e_size_r[(g > 0) ? g - 1 : 0];
          e_addr_r[g]  <= e_addr_r[(g > 0) ? g - 1 : 0];
          e_start_r[g] <= e_start_r[(g > 0) ? g - 1 : 0];
          e_ctx_r[g]   <= e_ctx_r[(g > 0) ? g - 1 : 0];
          e_queue_r[g] <= e_queue_r[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.commit && is_ins) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_hit = int'(req_idx_r) < int'(cnt_r);
  assign rd_idx = IDX_W'(req_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      kept_r     <= 1'b0;
      rank_r     <= '0;
      rd_valid_r <= 1'b0;
      rd_dur_r   <= '0;
      rd_size_r  <= '0;
      rd_addr_r  <= '0;
      rd_start_r <= '0;
      rd_ctx_r   <= '0;
      rd_queue_r <= '0;
      if (is_ins) begin
        kept_r <= ins_kept;
        rank_r <= RANK_W'(ins_rank);
        ecnt_r <= ECNT_W'(cnt_nxt);
      end else begin
        ecnt_r <= ECNT_W'(cnt_r);
        if (rd_hit) begin
          rd_valid_r <= 1'b1;
          rd_dur_r   <= e_dur_r[rd_idx];
          rd_size_r  <= e_size_r[rd_idx];
          rd_addr_r  <= e_addr_r[rd_idx];
          rd_start_r <= e_start_r[rd_idx];
          rd_ctx_r   <= e_ctx_r[rd_idx];
          rd_queue_r <= e_queue_r[rd_idx];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kept          = kept_r;
  assign out_rank          = rank_r;
  assign out_entry_count   = ecnt_r;
  assign out_rd_valid      = rd_valid_r;
  assign out_rd_duration   = rd_dur_r;
  assign out_rd_size       = rd_size_r;
  assign out_rd_address    = rd_addr_r;
  assign out_rd_context_id = rd_ctx_r;
  assign out_rd_queue_id   = rd_queue_r;
  assign out_rd_start_time = rd_start_r;

  `TKLT_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(TOP_COUNT), "entry count above capacity")
  `TKLT_ASSERT(a_one_slot, (cmd.commit && is_ins) |-> $onehot0(at), "more than one insert slot")
  `TKLT_ASSERT_NEXT(a_cnt_hold, !cmd.commit, $stable(cnt_r), "entry count moved without commit")

endmodule

FILE: rtl/top_k_longest_transfers.sv
// Top level of the top-k longest transfers list.
// Keeps the TOP_COUNT longest transfer records sorted by duration, longest at rank 0;
// ties go after equal entries, and a full list evicts its last entry or drops a record
// no longer than every stored one. Each input word (insert or read) gives one result
// word. After acceptance the word is captured, its duration is compared against all entries
// at once and the compare result registered, then the entries are shifted and written
// (or the read entry selected) as the result loads into the output register. A new word
// is accepted while idle or in the same cycle the previous result is loaded, never while
// a word is still in compare; a stalled output holds the update stage.
module top_k_longest_transfers (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [tklt_pkg::WIDE_W-1:0]   in_duration,
  input  logic [tklt_pkg::WIDE_W-1:0]   in_xfer_size,
  input  logic [tklt_pkg::WIDE_W-1:0]   in_xfer_address,
  input  logic [tklt_pkg::ID_W-1:0]     in_context_id,
  input  logic [tklt_pkg::ID_W-1:0]     in_queue_id,
  input  logic [tklt_pkg::WIDE_W-1:0]   in_start_time,
  input  logic [tklt_pkg::RIDX_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kept,
  output logic [tklt_pkg::RANK_W-1:0]   out_rank,
  output logic [tklt_pkg::ECNT_W-1:0]   out_entry_count,
  output logic                          out_rd_valid,
  output logic [tklt_pkg::WIDE_W-1:0]   out_rd_duration,
  output logic [tklt_pkg::WIDE_W-1:0]   out_rd_size,
  output logic [tklt_pkg::WIDE_W-1:0]   out_rd_address,
  output logic [tklt_pkg::ID_W-1:0]     out_rd_context_id,
  output logic [tklt_pkg::ID_W-1:0]     out_rd_queue_id,
  output logic [tklt_pkg::WIDE_W-1:0]   out_rd_start_time
);
  import tklt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tklt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tklt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_duration       (in_duration),
    .in_xfer_size      (in_xfer_size),
    .in_xfer_address   (in_xfer_address),
    .in_context_id     (in_context_id),
    .in_queue_id       (in_queue_id),
    .in_start_time     (in_start_time),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kept          (out_kept),
    .out_rank          (out_rank),
    .out_entry_count   (out_entry_count),
    .out_rd_valid      (out_rd_valid),
    .out_rd_duration   (out_rd_duration),
    .out_rd_size       (out_rd_size),
    .out_rd_address    (out_rd_address),
    .out_rd_context_id (out_rd_context_id),
    .out_rd_queue_id   (out_rd_queue_id),
    .out_rd_start_time (out_rd_start_time)
  );

endmodule

FILE: verif/top_k_longest_transfers_tb.sv
// Self-checking testbench for the top-k longest transfers list: random stalls, ranking predictor.
module top_k_longest_transfers_tb;
  import tklt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_TAIL   = 100;

  typedef struct packed {
    logic                req_type;
    logic [WIDE_W-1:0]   duration;
    logic [WIDE_W-1:0]   xfer_size;
    logic [WIDE_W-1:0]   xfer_address;
    logic [ID_W-1:0]     context_id;
    logic [ID_W-1:0]     queue_id;
    logic [WIDE_W-1:0]   start_time;
    logic [RIDX_W-1:0]   read_index;
  } xfer_word_t;

  typedef struct packed {
    logic                kept;
    logic [RANK_W-1:0]   rank;
    logic [ECNT_W-1:0]   entry_count;
    logic                rd_valid;
    logic [WIDE_W-1:0]   rd_duration;
    logic [WIDE_W-1:0]   rd_size;
    logic [WIDE_W-1:0]   rd_address;
    logic [ID_W-1:0]     rd_context_id;
    logic [ID_W-1:0]     rd_queue_id;
    logic [WIDE_W-1:0]   rd_start_time;
  } ranking_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_req_type = 1'b0;
  logic [WIDE_W-1:0]   in_duration = '0;
  logic [WIDE_W-1:0]   in_xfer_size = '0;
  logic [WIDE_W-1:0]   in_xfer_address = '0;
  logic [ID_W-1:0]     in_context_id = '0;
  logic [ID_W-1:0]     in_queue_id = '0;
  logic [WIDE_W-1:0]   in_start_time = '0;
  logic [RIDX_W-1:0]   in_read_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_kept;
  logic [RANK_W-1:0]   out_rank;
  logic [ECNT_W-1:0]   out_entry_count;
  logic                out_rd_valid;
  logic [WIDE_W-1:0]   out_rd_duration;
  logic [WIDE_W-1:0]   out_rd_size;
  logic [WIDE_W-1:0]   out_rd_address;
  logic [ID_W-1:0]     out_rd_context_id;
  logic [ID_W-1:0]     out_rd_queue_id;
  logic [WIDE_W-1:0]   out_rd_start_time;

  top_k_longest_transfers dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_duration       (in_duration),
    .in_xfer_size      (in_xfer_size),
    .in_xfer_address   (in_xfer_address),
    .in_context_id     (in_context_id),
    .in_queue_id       (in_queue_id),
    .in_start_time     (in_start_time),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kept          (out_kept),
    .out_rank          (out_rank),
    .out_entry_count   (out_entry_count),
    .out_rd_valid      (out_rd_valid),
    .out_rd_duration   (out_rd_duration),
    .out_rd_size       (out_rd_size),
    .out_rd_address    (out_rd_address),
    .out_rd_context_id (out_rd_context_id),
    .out_rd_queue_id   (out_rd_queue_id),
    .out_rd_start_time (out_rd_start_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the ranked list
  logic [WIDE_W-1:0] held_dur   [TOP_COUNT];
  logic [WIDE_W-1:0] held_size  [TOP_COUNT];
  logic [WIDE_W-1:0] held_addr  [TOP_COUNT];
  logic [WIDE_W-1:0] held_start [TOP_COUNT];
  logic [ID_W-1:0]   held_ctx   [TOP_COUNT];
  logic [ID_W-1:0]   held_queue [TOP_COUNT];
  int held_count = 0;

  xfer_word_t      pending_words[$];
  ranking_result_t expected_results[$];
  xfer_word_t      cur_word;
  ranking_result_t got_word;

  int errors = 0;
  int total_words = 0;
  int words_sent = 0;
  int results_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int n_kept = 0, n_dropped = 0, n_read_hit = 0, n_read_miss = 0;
  bit calm;

  function automatic logic [WIDE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ranking_result_t update_ranking(xfer_word_t w);
    ranking_result_t r;
    int pos, last;
    bit found;
    r = '0;
    found = 1'b0;
    if (w.req_type == REQ_INSERT) begin
      pos = held_count;
      for (int i = 0; i < held_count; i++) begin
        if (!found && w.duration > held_dur[i]) begin
          pos = i;
          found = 1'b1;
        end
      end
      // full list with nothing shorter: record is dropped
      if (pos < TOP_COUNT) begin
        last = (held_count < TOP_COUNT) ? held_count : TOP_COUNT - 1;
        for (int i = last; i > pos; i--) begin
          held_dur[i]   = held_dur[i-1];
          held_size[i]  = held_size[i-1];
          held_addr[i]  = held_addr[i-1];
          held_start[i] = held_start[i-1];
          held_ctx[i]   = held_ctx[i-1];
          held_queue[i] = held_queue[i-1];
        end
        held_dur[pos]   = w.duration;
        held_size[pos]  = w.xfer_size;
        held_addr[pos]  = w.xfer_address;
        held_start[pos] = w.start_time;
        held_ctx[pos]   = w.context_id;
        held_queue[pos] = w.queue_id;
        if (held_count < TOP_COUNT) held_count++;
        r.kept = 1'b1;
        r.rank = pos[RANK_W-1:0];
        n_kept++;
      end else begin
        n_dropped++;
      end
    end else begin
      if (int'(w.read_index) < held_count) begin
        r.rd_valid      = 1'b1;
        r.rd_duration   = held_dur[w.read_index];
        r.rd_size       = held_size[w.read_index];
        r.rd_address    = held_addr[w.read_index];
        r.rd_context_id = held_ctx[w.read_index];
        r.rd_queue_id   = held_queue[w.read_index];
        r.rd_start_time = held_start[w.read_index];
        n_read_hit++;
      end else begin
        n_read_miss++;
      end
    end
    r.entry_count = held_count[ECNT_W-1:0];
    return r;
  endfunction

  task automatic push_insert(input logic [WIDE_W-1:0] dur, input logic [WIDE_W-1:0] size,
                             input logic [WIDE_W-1:0] addr, input logic [ID_W-1:0] ctx,
                             input logic [ID_W-1:0] qid, input logic [WIDE_W-1:0] start);
    xfer_word_t w;
    w.req_type     = REQ_INSERT;
    w.duration     = dur;
    w.xfer_size    = size;
    w.xfer_address = addr;
    w.context_id   = ctx;
    w.queue_id     = qid;
    w.start_time   = start;
    w.read_index   = RIDX_W'($urandom_range(0, 15));
    pending_words = {pending_words, w};
  endtask

  // payload of a read is don't-care, so it is randomized
  task automatic push_read(input int idx);
    xfer_word_t w;
    w.req_type     = REQ_READ;
    w.duration     = rand64();
    w.xfer_size    = rand64();
    w.xfer_address = rand64();
    w.context_id   = ID_W'($urandom_range(0, 65535));
    w.queue_id     = ID_W'($urandom_range(0, 65535));
    w.start_time   = rand64();
    w.read_index   = idx[RIDX_W-1:0];
    pending_words = {pending_words, w};
  endtask

  task automatic compare_field(input string name, input logic [WIDE_W-1:0] want,
                               input logic [WIDE_W-1:0] got);
    if (want !== got) begin
      if (errors < 50)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input ranking_result_t got);
    ranking_result_t want;
    if (expected_results.size() == 0) begin
      if (errors < 50)
        $display("%0t: result word with nothing expected: expected none, actual %0h",
                 $time, got);
      errors++;
    end else begin
      want = expected_results.pop_front();
      compare_field("kept",          WIDE_W'(want.kept),          WIDE_W'(got.kept));
      compare_field("rank",          WIDE_W'(want.rank),          WIDE_W'(got.rank));
      compare_field("entry_count",   WIDE_W'(want.entry_count),   WIDE_W'(got.entry_count));
      compare_field("rd_valid",      WIDE_W'(want.rd_valid),      WIDE_W'(got.rd_valid));
      compare_field("rd_duration",   want.rd_duration,            got.rd_duration);
      compare_field("rd_size",       want.rd_size,                got.rd_size);
      compare_field("rd_address",    want.rd_address,             got.rd_address);
      compare_field("rd_context_id", WIDE_W'(want.rd_context_id), WIDE_W'(got.rd_context_id));
      compare_field("rd_queue_id",   WIDE_W'(want.rd_queue_id),   WIDE_W'(got.rd_queue_id));
      compare_field("rd_start_time", want.rd_start_time,          got.rd_start_time);
    end
  endtask

  // Driver: presents queued words, random gap bursts between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, update_ranking(cur_word)};
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        calm = (pending_words.size() < CALM_TAIL) || (((words_sent / 60) % 4) == 1);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && pending_words.size() != 0 && $urandom_range(0, 99) < 15) begin
          gap_left = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_req_type     <= cur_word.req_type;
          in_duration     <= cur_word.duration;
          in_xfer_size    <= cur_word.xfer_size;
          in_xfer_address <= cur_word.xfer_address;
          in_context_id   <= cur_word.context_id;
          in_queue_id     <= cur_word.queue_id;
          in_start_time   <= cur_word.start_time;
          in_read_index   <= cur_word.read_index;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted result words, random stall bursts on out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_word.kept          = out_kept;
        got_word.rank          = out_rank;
        got_word.entry_count   = out_entry_count;
        got_word.rd_valid      = out_rd_valid;
        got_word.rd_duration   = out_rd_duration;
        got_word.rd_size       = out_rd_size;
        got_word.rd_address    = out_rd_address;
        got_word.rd_context_id = out_rd_context_id;
        got_word.rd_queue_id   = out_rd_queue_id;
        got_word.rd_start_time = out_rd_start_time;
        check_result(got_word);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!(results_seen >= total_words - CALM_TAIL || ((results_seen / 60) % 4) == 3)
                   && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [WIDE_W-1:0] ramp, dur;
    logic [WIDE_W-1:0] recent_dur [16];
    int pick, n_ins;

    // directed: empty reads, extremes, ties, fill, drop, evict
    push_read(0);
    push_read(15);
    push_insert('1, '1, '1, '1, '1, '1);
    push_insert('1, rand64(), rand64(), 16'h0, 16'h0, rand64());  // tie lands after
    push_insert('0, '0, '0, '0, '0, '0);
    push_read(1);
    for (int k = 0; k < 13; k++)
      push_insert(64'd1000 + WIDE_W'(((k * 7) % 13) * 10), rand64(), rand64(),
                  ID_W'($urandom_range(0, 65535)), ID_W'($urandom_range(0, 65535)), rand64());
    push_insert(64'd0, rand64(), rand64(), 16'h1234, 16'h4321, rand64());  // full, dropped
    push_insert(64'd1, rand64(), rand64(), 16'hffff, 16'h0, rand64());     // evicts last
    push_insert(64'd1040, rand64(), rand64(), 16'h0, 16'hffff, rand64());  // tie mid-list
    push_read(15);
    push_read(0);
    push_read(7);

    // random: rising duration window keeps inserts landing at varied ranks
    ramp = 64'd16;
    n_ins = 0;
    for (int i = 0; i < 16; i++) recent_dur[i] = '0;
    for (int n = 0; n < 750; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        push_read($urandom_range(0, 15));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          dur = ramp - (ramp >> 2) + rand64() % ((ramp >> 1) + WIDE_W'(1));
        else if (pick < 80)
          dur = recent_dur[$urandom_range(0, 15)];
        else if (pick < 96)
          dur = WIDE_W'($urandom_range(0, 15));
        else if (pick < 97)
          dur = rand64();
        else
          dur = ramp;
        recent_dur[n_ins % 16] = dur;
        n_ins++;
        if (ramp[WIDE_W-1:WIDE_W-4] == 4'h0) ramp = ramp + (ramp >> 4) + WIDE_W'(1);
        push_insert(dur, rand64(), rand64(), ID_W'($urandom_range(0, 65535)),
                    ID_W'($urandom_range(0, 65535)), rand64());
      end
    end
    total_words = pending_words.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words: %0d inserts kept, %0d dropped as too short.",
             words_sent, n_kept, n_dropped);
    $display("Reads: %0d inside the list, %0d past its end; %0d result words checked.",
             n_read_hit, n_read_miss, results_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
